@@ rtl/tspb_pkg.sv @@
package tspb_pkg;

    // Slots per frame; each slot drives channel s and channel s + MAX_SLOTS.
    localparam int MAX_SLOTS = 6;
    localparam int NUM_CH    = 2 * MAX_SLOTS;

    localparam int TICK_W    = 16;
    localparam int VAL_W     = 13;
    localparam int CH_W      = 4;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;

    // Item operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_POS  = 2'd1;
    localparam logic [1:0] OP_TRIM = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 4'd3;

    // Reset values of the configuration registers.
    localparam logic [TICK_W-1:0] SLOT_TICKS_RST   = 16'd6000;
    localparam logic [TICK_W-1:0] GAP_TICKS_RST    = 16'd2000;
    localparam logic [SLOT_W-1:0] ACTIVE_SLOTS_RST = 3'd6;
    localparam logic [NUM_CH-1:0] INVERT_MASK_RST  = 12'd1228;

    typedef struct packed {
        logic [TICK_W-1:0] slot_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [SLOT_W-1:0] active_slots;
        logic [NUM_CH-1:0] invert_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              op;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] width_a;
        logic [TICK_W-1:0] width_b;
    } slot_width_t;

    typedef struct packed {
        logic [NUM_CH-1:0] pins;
        logic [SLOT_W-1:0] slot;
        logic              frame_start;
    } result_t;

endpackage

@@ rtl/tspb_chan_table.sv @@
// Position and trim storage, split into the low and high channel banks so that
// each bank is read at the one slot about to begin, plus the logic that computes the widths to latch.
module tspb_chan_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  tspb_pkg::item_t                     item,
    input  tspb_pkg::cfg_t                      cfg,
    input  logic [tspb_pkg::SLOT_W-1:0]         rd_slot,
    output tspb_pkg::slot_width_t               widths
);

    logic signed [tspb_pkg::VAL_W-1:0] pos_a_reg  [tspb_pkg::MAX_SLOTS];
    logic signed [tspb_pkg::VAL_W-1:0] pos_b_reg  [tspb_pkg::MAX_SLOTS];
    logic signed [tspb_pkg::VAL_W-1:0] trim_a_reg [tspb_pkg::MAX_SLOTS];
    logic signed [tspb_pkg::VAL_W-1:0] trim_b_reg [tspb_pkg::MAX_SLOTS];

    logic                              ch_ok;
    logic                              ch_high;
    logic [tspb_pkg::CH_W-1:0]         ch_off;
    logic [tspb_pkg::SLOT_W-1:0]       wr_idx;
    logic                              rd_ok;
    logic [tspb_pkg::CH_W-1:0]         rd_ch_b;
    logic signed [tspb_pkg::VAL_W-1:0] pa;
    logic signed [tspb_pkg::VAL_W-1:0] pb;
    logic signed [tspb_pkg::VAL_W-1:0] ta;
    logic signed [tspb_pkg::VAL_W-1:0] tb;
    logic                              inv_a;
    logic                              inv_b;

    // Width is 2*(trim+position) clamped to 0..slot_ticks, mirrored for
    // inverted channels.
    function automatic logic [tspb_pkg::TICK_W-1:0] width_of(
        input logic signed [tspb_pkg::VAL_W-1:0] p,
        input logic signed [tspb_pkg::VAL_W-1:0] t,
        input logic [tspb_pkg::TICK_W-1:0]       st,
        input logic                              inv
    );
        logic signed [tspb_pkg::VAL_W:0] sum;
        logic [tspb_pkg::VAL_W:0]        mag;
        logic [tspb_pkg::TICK_W-1:0]     clamped;
        sum = (tspb_pkg::VAL_W+1)'(p) + (tspb_pkg::VAL_W+1)'(t);
        mag = {sum[tspb_pkg::VAL_W-1:0], 1'b0};
        if (sum[tspb_pkg::VAL_W]) begin
            clamped = '0;
        end
        else if (tspb_pkg::TICK_W'(mag) > st) begin
            clamped = st;
        end
        else begin
            clamped = tspb_pkg::TICK_W'(mag);
        end
        return inv ? (st - clamped) : clamped;
    endfunction

    assign ch_ok   = (item.channel < tspb_pkg::CH_W'(tspb_pkg::NUM_CH));
    assign ch_high = (item.channel >= tspb_pkg::CH_W'(tspb_pkg::MAX_SLOTS));
    assign ch_off  = ch_high ? (item.channel - tspb_pkg::CH_W'(tspb_pkg::MAX_SLOTS))
                             : item.channel;
    assign wr_idx  = ch_off[tspb_pkg::SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tspb_pkg::MAX_SLOTS; i++)
            begin
                pos_a_reg[i]  <= '0;
                pos_b_reg[i]  <= '0;
                trim_a_reg[i] <= '0;
                trim_b_reg[i] <= '0;
            end
        end
        else if (fire && ch_ok)
        begin
            if (item.op == tspb_pkg::OP_POS)
            begin
                if (ch_high)
                begin
                    pos_b_reg[wr_idx] <= item.value;
                end
                else
                begin
                    pos_a_reg[wr_idx] <= item.value;
                end
            end
            else if (item.op == tspb_pkg::OP_TRIM)
            begin
                if (ch_high)
                begin
                    trim_b_reg[wr_idx] <= item.value;
                end
                else
                begin
                    trim_a_reg[wr_idx] <= item.value;
                end
            end
        end
    end

    // While the last slot of a six-slot frame runs, the slot index points past the
    // last bank entry; that read is never used, so it returns zero.
    assign rd_ok   = (rd_slot < tspb_pkg::SLOT_W'(tspb_pkg::MAX_SLOTS));
    assign rd_ch_b = tspb_pkg::CH_W'(rd_slot) + tspb_pkg::CH_W'(tspb_pkg::MAX_SLOTS);

    always_comb
    begin
        pa    = '0;
        pb    = '0;
        ta    = '0;
        tb    = '0;
        inv_a = 1'b0;
        inv_b = 1'b0;
        if (rd_ok)
        begin
            pa    = pos_a_reg[rd_slot];
            pb    = pos_b_reg[rd_slot];
            ta    = trim_a_reg[rd_slot];
            tb    = trim_b_reg[rd_slot];
            inv_a = cfg.invert_mask[rd_slot];
            inv_b = cfg.invert_mask[rd_ch_b];
        end
    end

    assign widths.width_a = width_of(pa, ta, cfg.slot_ticks, inv_a);
    assign widths.width_b = width_of(pb, tb, cfg.slot_ticks, inv_b);

endmodule

@@ rtl/tspb_sequencer.sv @@
// Slot and gap sequencer: tick counter, slot index, latched widths and pin
// levels. Presents the next-state result for the output register.
module tspb_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  tspb_pkg::item_t                     item,
    input  tspb_pkg::cfg_t                      cfg,
    input  tspb_pkg::slot_width_t               widths,
    output logic [tspb_pkg::SLOT_W-1:0]         rd_slot,
    output tspb_pkg::result_t                   result
);

    logic [tspb_pkg::SLOT_W-1:0] slot_index_reg;
    logic [tspb_pkg::SLOT_W-1:0] slot_index_next;
    logic [tspb_pkg::TICK_W-1:0] tick_count_reg;
    logic [tspb_pkg::TICK_W-1:0] tick_count_next;
    logic [tspb_pkg::TICK_W-1:0] width_a_reg;
    logic [tspb_pkg::TICK_W-1:0] width_a_next;
    logic [tspb_pkg::TICK_W-1:0] width_b_reg;
    logic [tspb_pkg::TICK_W-1:0] width_b_next;
    logic [tspb_pkg::NUM_CH-1:0] pins_reg;
    logic [tspb_pkg::NUM_CH-1:0] pins_next;

    logic [tspb_pkg::SLOT_W-1:0] act;
    logic [tspb_pkg::TICK_W-1:0] count;
    logic                        done;
    logic                        fs;
    logic [tspb_pkg::SLOT_W-1:0] cur_a;
    logic [tspb_pkg::NUM_CH-1:0] run_bits;
    logic [tspb_pkg::NUM_CH-1:0] bit_a;
    logic [tspb_pkg::NUM_CH-1:0] bit_b;
    logic [tspb_pkg::NUM_CH-1:0] new_a;
    logic [tspb_pkg::NUM_CH-1:0] new_b;

    // Active slot count saturated to 1..MAX_SLOTS.
    always_comb
    begin
        if (cfg.active_slots == '0)
        begin
            act = tspb_pkg::SLOT_W'(1);
        end
        else if (cfg.active_slots > tspb_pkg::SLOT_W'(tspb_pkg::MAX_SLOTS))
        begin
            act = tspb_pkg::SLOT_W'(tspb_pkg::MAX_SLOTS);
        end
        else
        begin
            act = cfg.active_slots;
        end
    end

    assign rd_slot = slot_index_reg;
    assign count   = tick_count_reg + tspb_pkg::TICK_W'(1);
    assign cur_a   = slot_index_reg - tspb_pkg::SLOT_W'(1);
    assign bit_a   = tspb_pkg::NUM_CH'(1) << cur_a;
    assign bit_b   = tspb_pkg::NUM_CH'(1) << (tspb_pkg::CH_W'(cur_a)
                     + tspb_pkg::CH_W'(tspb_pkg::MAX_SLOTS));
    assign new_a   = tspb_pkg::NUM_CH'(1) << slot_index_reg;
    assign new_b   = tspb_pkg::NUM_CH'(1) << (tspb_pkg::CH_W'(slot_index_reg)
                     + tspb_pkg::CH_W'(tspb_pkg::MAX_SLOTS));

    always_comb
    begin
        slot_index_next = slot_index_reg;
        tick_count_next = tick_count_reg;
        width_a_next    = width_a_reg;
        width_b_next    = width_b_reg;
        run_bits        = pins_reg;
        pins_next       = pins_reg;
        done            = 1'b0;
        fs              = 1'b0;
        if (item.op == tspb_pkg::OP_TICK)
        begin
            if (slot_index_reg != '0)
            begin
                if (count >= width_a_reg)
                begin
                    run_bits = run_bits & ~bit_a;
                end
                if (count >= width_b_reg)
                begin
                    run_bits = run_bits & ~bit_b;
                end
                if (count >= cfg.slot_ticks)
                begin
                    run_bits = run_bits & ~(bit_a | bit_b);
                    done     = 1'b1;
                end
            end
            else if (count >= cfg.gap_ticks)
            begin
                done = 1'b1;
            end
            pins_next = run_bits;
            if (done)
            begin
                tick_count_next = '0;
                if (slot_index_reg < act)
                begin
                    width_a_next = widths.width_a;
                    width_b_next = widths.width_b;
                    if (widths.width_a != '0)
                    begin
                        pins_next = pins_next | new_a;
                    end
                    if (widths.width_b != '0)
                    begin
                        pins_next = pins_next | new_b;
                    end
                    fs              = (slot_index_reg == '0);
                    slot_index_next = slot_index_reg + tspb_pkg::SLOT_W'(1);
                end
                else
                begin
                    slot_index_next = '0;
                end
            end
            else
            begin
                tick_count_next = count;
            end
        end
    end

    assign result.pins        = pins_next;
    assign result.slot        = (slot_index_next == '0) ? act
                                : (slot_index_next - tspb_pkg::SLOT_W'(1));
    assign result.frame_start = fs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg <= '0;
            tick_count_reg <= '0;
            width_a_reg    <= '0;
            width_b_reg    <= '0;
            pins_reg       <= '0;
        end
        else if (fire)
        begin
            slot_index_reg <= slot_index_next;
            tick_count_reg <= tick_count_next;
            width_a_reg    <= width_a_next;
            width_b_reg    <= width_b_next;
            pins_reg       <= pins_next;
        end
    end

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_index_reg <= tspb_pkg::SLOT_W'(tspb_pkg::MAX_SLOTS))
        else $error("slot index beyond the last slot");

    a_gap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_index_reg == '0) |-> (pins_reg == '0))
        else $error("pin high during the gap");

    a_two_pins: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pins_reg) <= 2)
        else $error("more than the two channels of one slot are high");
`endif

endmodule

@@ rtl/timeslot_servo_pwm_bank_core.sv @@
// Time-multiplexed servo pulse generator for twelve channels. Every input
// transfer is a tick of the pulse timebase, a position write or a trim write;
// every input transfer yields exactly one output transfer carrying the pin
// levels, the current slot number (the active slot count while the gap runs)
// and a frame-start flag. The block takes one transfer per clock for as long
// as the output side keeps taking results. A result is registered: the item
// is held in the input register, passes through the sequencer into the output
// register once that register is free or being emptied, and the output
// transfer then completes when the receiver takes it.
// That single register-to-register pass through the width latch and tick
// compare sets the rate. Configuration must only be written while no transfer
// is in flight.
module timeslot_servo_pwm_bank_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // [3:0] channel, [16:4] value, rest zero
    input  logic [1:0]                        s_tuser,  // [1:0] op
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // [11:0] pins, [14:12] slot, rest zero
    output logic [0:0]                        m_tuser,  // [0] frame_start
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [tspb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tspb_pkg::CFG_W-1:0]        cfg_data
);

    tspb_pkg::cfg_t         cfg_reg;
    tspb_pkg::item_t        item_reg;
    logic                   in_valid_reg;
    tspb_pkg::result_t      res_reg;
    logic                   out_valid_reg;

    tspb_pkg::slot_width_t  widths;
    tspb_pkg::result_t      res_next;
    logic [tspb_pkg::SLOT_W-1:0] rd_slot;
    logic                   fire;
    logic                   in_take;

    // The sequencer works whenever an item is held and the output register
    // is free or being emptied in the same cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_ticks   <= tspb_pkg::SLOT_TICKS_RST;
            cfg_reg.gap_ticks    <= tspb_pkg::GAP_TICKS_RST;
            cfg_reg.active_slots <= tspb_pkg::ACTIVE_SLOTS_RST;
            cfg_reg.invert_mask  <= tspb_pkg::INVERT_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tspb_pkg::REG_SLOT_TICKS:   cfg_reg.slot_ticks   <= cfg_data;
                tspb_pkg::REG_GAP_TICKS:    cfg_reg.gap_ticks    <= cfg_data;
                tspb_pkg::REG_ACTIVE_SLOTS:
                    cfg_reg.active_slots <= cfg_data[tspb_pkg::SLOT_W-1:0];
                tspb_pkg::REG_INVERT_MASK:
                    cfg_reg.invert_mask  <= cfg_data[tspb_pkg::NUM_CH-1:0];
                default: ;
            endcase
        end
    end

    // Input and output valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op      <= s_tuser;
            item_reg.channel <= s_tdata[tspb_pkg::CH_W-1:0];
            item_reg.value   <= s_tdata[tspb_pkg::CH_W+tspb_pkg::VAL_W-1:tspb_pkg::CH_W];
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    tspb_chan_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .rd_slot (rd_slot),
        .widths  (widths)
    );

    tspb_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .widths  (widths),
        .rd_slot (rd_slot),
        .result  (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.slot, res_reg.pins};
    assign m_tuser  = res_reg.frame_start;

`ifndef SYNTHESIS
    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with no item held");

    a_frame_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.frame_start) |-> (res_reg.slot == '0))
        else $error("frame start reported outside slot zero");
`endif

endmodule

@@ test/tb_timeslot_servo_pwm_bank_core.sv @@
`timescale 1ns / 100ps

// Testbench for the time-multiplexed servo pulse generator. Every input
// transfer is a tick, a position write or a trim write, and each one yields
// exactly one output transfer. A behavioural model of the frame sequencer
// runs alongside the block. It is stepped once for every accepted input
// transfer, and its prediction is queued. Every output transfer is then
// checked against the oldest prediction, field by field.
module tb_timeslot_servo_pwm_bank_core;

    // The package names three operations. The fourth encoding is spare and
    // must leave the block untouched.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES  = 4;     // pause before a register write
    localparam int DRAIN_CYCLES   = 8;     // pause before the verdict

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value
    // from time zero.
    // ------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [23:0]                    s_tdata   = '0;  // [3:0] channel, [16:4] value, rest zero
    logic [1:0]                     s_tuser   = '0;  // [1:0] op
    logic                           m_tready  = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tspb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tspb_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           s_tready;
    logic                           m_tvalid;
    logic [15:0]                    m_tdata;         // [11:0] pins, [14:12] slot, rest zero
    logic [0:0]                     m_tuser;         // [0] frame_start

    always #2 clk = ~clk;

    timeslot_servo_pwm_bank_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Model state. This is a shadow of the register file and of the
    // sequencer, kept at the block's own widths where that matters.
    // ------------------------------------------------------------------
    tspb_pkg::cfg_t                    cfg_shadow;
    logic signed [tspb_pkg::VAL_W-1:0] position_mem [tspb_pkg::NUM_CH];
    logic signed [tspb_pkg::VAL_W-1:0] trim_mem     [tspb_pkg::NUM_CH];
    int                                next_slot;    // 0 while the gap runs, else slot + 1
    int                                phase_ticks;  // ticks elapsed in the current phase
    int                                width_lo;     // latched width of channel s
    int                                width_hi;     // latched width of channel s + MAX_SLOTS
    logic [tspb_pkg::NUM_CH-1:0]       pin_state;

    // Pin reports that the block owes us, oldest first.
    tspb_pkg::result_t pending_reports[$];

    // The idle and stall rates, in percent per cycle, for the current phase.
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    int errors     = 0;
    int n_items    = 0;
    int n_ticks    = 0;
    int n_writes   = 0;
    int n_frames   = 0;
    int n_settings = 0;

    // ------------------------------------------------------------------
    // Model of the sequencer.
    // ------------------------------------------------------------------

    // Frames always hold between one slot and MAX_SLOTS slots, whatever the
    // register says.
    function automatic int slots_in_frame();
        int a;
        a = int'(cfg_shadow.active_slots);
        if (a < 1)
        begin
            a = 1;
        end
        if (a > tspb_pkg::MAX_SLOTS)
        begin
            a = tspb_pkg::MAX_SLOTS;
        end
        return a;
    endfunction

    // This is the pulse width latched when a channel's slot begins. It is
    // twice the sum of trim and position, clamped into the slot, and
    // mirrored for inverted channels.
    function automatic int pulse_width(int ch);
        int n;
        int st;
        st = int'(cfg_shadow.slot_ticks);
        n  = 2 * (int'(trim_mem[ch]) + int'(position_mem[ch]));
        if (n < 0)
        begin
            n = 0;
        end
        if (n > st)
        begin
            n = st;
        end
        if (cfg_shadow.invert_mask[ch])
        begin
            n = st - n;
        end
        return n;
    endfunction

    task automatic reset_servo_model();
        cfg_shadow.slot_ticks   = tspb_pkg::SLOT_TICKS_RST;
        cfg_shadow.gap_ticks    = tspb_pkg::GAP_TICKS_RST;
        cfg_shadow.active_slots = tspb_pkg::ACTIVE_SLOTS_RST;
        cfg_shadow.invert_mask  = tspb_pkg::INVERT_MASK_RST;
        for (int i = 0; i < tspb_pkg::NUM_CH; i++)
        begin
            position_mem[i] = '0;
            trim_mem[i]     = '0;
        end
        next_slot   = 0;
        phase_ticks = 0;
        width_lo    = 0;
        width_hi    = 0;
        pin_state   = '0;
    endtask

    // Advance the model by one accepted input and return the pin report it
    // produces.
    task automatic advance_servo(input tspb_pkg::item_t it, output tspb_pkg::result_t rep);
        int   act;
        int   count;
        int   c;
        int   cur;
        logic done;
        logic fs;
        act  = slots_in_frame();
        done = 1'b0;
        fs   = 1'b0;
        if (it.op == tspb_pkg::OP_POS && it.channel < tspb_pkg::NUM_CH)
        begin
            position_mem[it.channel] = it.value;
        end
        else if (it.op == tspb_pkg::OP_TRIM && it.channel < tspb_pkg::NUM_CH)
        begin
            trim_mem[it.channel] = it.value;
        end
        else if (it.op == tspb_pkg::OP_TICK)
        begin
            count = phase_ticks + 1;
            if (next_slot != 0)
            begin
                // Each channel drops once its width is reached. Both are
                // forced low when the slot itself runs out.
                c = next_slot - 1;
                if (count >= width_lo)
                begin
                    pin_state[c] = 1'b0;
                end
                if (count >= width_hi)
                begin
                    pin_state[c + tspb_pkg::MAX_SLOTS] = 1'b0;
                end
                if (count >= int'(cfg_shadow.slot_ticks))
                begin
                    pin_state[c]                       = 1'b0;
                    pin_state[c + tspb_pkg::MAX_SLOTS] = 1'b0;
                    done                               = 1'b1;
                end
            end
            else if (count >= int'(cfg_shadow.gap_ticks))
            begin
                done = 1'b1;
            end
            if (done)
            begin
                // The next phase begins on the same tick that ends this one.
                phase_ticks = 0;
                if (next_slot < act)
                begin
                    width_lo = pulse_width(next_slot);
                    width_hi = pulse_width(next_slot + tspb_pkg::MAX_SLOTS);
                    if (width_lo != 0)
                    begin
                        pin_state[next_slot] = 1'b1;
                    end
                    if (width_hi != 0)
                    begin
                        pin_state[next_slot + tspb_pkg::MAX_SLOTS] = 1'b1;
                    end
                    fs        = (next_slot == 0);
                    next_slot = next_slot + 1;
                end
                else
                begin
                    next_slot = 0;
                end
            end
            else
            begin
                phase_ticks = count;
            end
        end
        cur             = (next_slot == 0) ? act : next_slot - 1;
        rep.pins        = pin_state;
        rep.slot        = cur[tspb_pkg::SLOT_W-1:0];
        rep.frame_start = fs;
    endtask

    // ------------------------------------------------------------------
    // Driving the block.
    // ------------------------------------------------------------------

    function automatic tspb_pkg::item_t make_item(logic [1:0] op, int ch, int v);
        tspb_pkg::item_t it;
        it.op      = op;
        it.channel = ch[tspb_pkg::CH_W-1:0];
        it.value   = v[tspb_pkg::VAL_W-1:0];
        return it;
    endfunction

    // Offer one item and hold it until the block takes it. The caller is
    // always just past a rising edge. The valid stays high afterwards, so
    // the next call or wait_for_idle decides what happens to it.
    task automatic send_item(input tspb_pkg::item_t it);
        tspb_pkg::result_t rep;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {7'b0, it.value, it.channel};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        advance_servo(it, rep);
        pending_reports.push_back(rep);
        n_items++;
        if (it.op == tspb_pkg::OP_TICK)
        begin
            n_ticks++;
        end
        else if (it.op != OP_SPARE && it.channel < tspb_pkg::NUM_CH)
        begin
            n_writes++;
        end
    endtask

    // Stop offering items and wait until every owed report has come back.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers in index order, then write one index that
    // does not exist. The block must ignore that last write, so the model
    // ignores it too. Data bits above a register's width are dropped.
    task automatic configure(input logic [tspb_pkg::CFG_W-1:0] st, gap, act, mask);
        logic [tspb_pkg::CFG_IDX_W-1:0] idx [5];
        logic [tspb_pkg::CFG_W-1:0]     val [5];
        idx = '{tspb_pkg::REG_SLOT_TICKS, tspb_pkg::REG_GAP_TICKS,
                tspb_pkg::REG_ACTIVE_SLOTS, tspb_pkg::REG_INVERT_MASK,
                tspb_pkg::CFG_IDX_W'($urandom_range(4, 15))};
        val = '{st, gap, act, mask, tspb_pkg::CFG_W'($urandom)};
        wait_for_idle();
        for (int k = 0; k < 5; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            case (idx[k])
                tspb_pkg::REG_SLOT_TICKS:   cfg_shadow.slot_ticks = val[k];
                tspb_pkg::REG_GAP_TICKS:    cfg_shadow.gap_ticks  = val[k];
                tspb_pkg::REG_ACTIVE_SLOTS:
                    cfg_shadow.active_slots = val[k][tspb_pkg::SLOT_W-1:0];
                tspb_pkg::REG_INVERT_MASK:
                    cfg_shadow.invert_mask  = val[k][tspb_pkg::NUM_CH-1:0];
                default:                    ;
            endcase
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Build a random item. Ticks make up most of the traffic. Writes mostly
    // carry values that give widths inside the slot, so that pulses end at
    // varied points. A smaller share carries negative or full-range values,
    // goes to channels that do not exist, or uses the spare operation.
    function automatic tspb_pkg::item_t random_item();
        tspb_pkg::item_t it;
        int              pick;
        int              sub;
        int              lim;
        int              v;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        v    = int'($urandom_range(0, 8191)) - 4096;
        if (pick < 70)
        begin
            it = make_item(tspb_pkg::OP_TICK, $urandom_range(0, 15), v);
        end
        else if (pick < 94)
        begin
            it.op = (pick < 82) ? tspb_pkg::OP_POS : tspb_pkg::OP_TRIM;
            lim   = int'(cfg_shadow.slot_ticks) / 2 + 1;
            if (lim > 4095)
            begin
                lim = 4095;
            end
            if (sub < 6)
            begin
                v = (it.op == tspb_pkg::OP_POS) ? int'($urandom_range(0, lim))
                                                : int'($urandom_range(0, 6)) - 3;
            end
            else if (sub < 8)
            begin
                v = 0 - int'($urandom_range(0, 8));
            end
            it = make_item(it.op,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                                        : $urandom_range(0, 11),
                           v);
        end
        else
        begin
            it = make_item(OP_SPARE, $urandom_range(0, 15), v);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Output side. The receiver stalls at the current phase's rate, and
    // every output transfer is checked against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    tspb_pkg::result_t want;
    tspb_pkg::result_t seen;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.pins        = m_tdata[tspb_pkg::NUM_CH-1:0];
            seen.slot        = m_tdata[tspb_pkg::NUM_CH+tspb_pkg::SLOT_W-1:tspb_pkg::NUM_CH];
            seen.frame_start = m_tuser[0];
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transfer, got pins %03h slot %0d start %0b",
                         $time, seen.pins, seen.slot, seen.frame_start);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (want.frame_start)
                begin
                    n_frames++;
                end
                if (seen.pins !== want.pins)
                begin
                    errors++;
                    $display("%0t: pins mismatch, expected %03h, got %03h",
                             $time, want.pins, seen.pins);
                end
                if (seen.slot !== want.slot)
                begin
                    errors++;
                    $display("%0t: slot mismatch, expected %0d, got %0d",
                             $time, want.slot, seen.slot);
                end
                if (seen.frame_start !== want.frame_start)
                begin
                    errors++;
                    $display("%0t: frame_start mismatch, expected %0b, got %0b",
                             $time, want.frame_start, seen.frame_start);
                end
            end
        end
    end

    // The watchdog ends the run if neither side moves a transfer for too
    // long. That covers a hung handshake and a report that never arrives.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
                 $time, WATCHDOG_LIMIT, pending_reports.size());
        $display("FAIL timeslot_servo_pwm_bank_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Straight out of reset the block sits in a long gap, so every report
    // shows the gap slot and all pins low. The spare operation must change
    // nothing.
    task automatic test_reset_gap();
        send_item(make_item(tspb_pkg::OP_TICK, 0, 0));
        send_item(make_item(tspb_pkg::OP_TICK, 15, -1));
        send_item(make_item(OP_SPARE, 3, 77));
        send_item(make_item(tspb_pkg::OP_TICK, 0, 0));
    endtask

    // This uses a short frame of two four-tick slots. Channel 0 gets a
    // two-tick pulse. Channel 1 gets the value extremes, whose sum gives a
    // zero width, so it never rises. Channel 6 is inverted from a zero
    // position and so fills its slot. Channel 7 is clamped to the slot
    // length. A write to a channel that does not exist and the spare
    // operation must leave all of this alone. A later position write to channel
    // 0 made during the gap only shows when its slot next starts.
    task automatic test_pulse_widths();
        configure(16'd4, 16'd2, 16'd2, 16'h0040);
        send_item(make_item(tspb_pkg::OP_POS, 0, 1));
        send_item(make_item(tspb_pkg::OP_POS, 1, 4095));
        send_item(make_item(tspb_pkg::OP_TRIM, 1, -4096));
        send_item(make_item(tspb_pkg::OP_POS, 7, 4095));
        send_item(make_item(tspb_pkg::OP_TRIM, 7, -1));
        send_item(make_item(tspb_pkg::OP_POS, 13, 3));
        send_item(make_item(OP_SPARE, 5, 100));
        repeat (10) send_item(make_item(tspb_pkg::OP_TICK, 15, -1));
        send_item(make_item(tspb_pkg::OP_POS, 0, 2));
        repeat (7) send_item(make_item(tspb_pkg::OP_TICK, 0, 0));
    endtask

    // Run one random phase of count items under one register setting and
    // one idling pattern. Items that the block ignores count as well.
    task automatic run_phase(input logic [tspb_pkg::CFG_W-1:0] st, gap, act, mask,
                             input int idle_pct, stall_pct, count);
        tspb_pkg::item_t it;
        int              done_items;
        configure(st, gap, act, mask);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        done_items    = 0;
        while (done_items < count)
        begin
            it = random_item();
            send_item(it);
            done_items++;
        end
    endtask

    // These random phases run one after another, and each carries the
    // sequencer state over into the next. Several cases come from that.
    // Lengths change under a running phase. A slot count of zero saturates
    // to one, and a slot count above six saturates to six. Zero lengths act
    // as one tick. The largest lengths hold a phase open. A drop from six
    // slots to two lands in the middle of a frame.
    task automatic test_random_traffic();
        run_phase(16'd8,     16'd3,     16'd6,     16'h0A5C, 0,  0,  300);
        run_phase(16'd1,     16'd1,     16'd3,     16'h0FFF, 80, 0,  200);
        run_phase(16'd20,    16'd5,     16'hFFFF,  16'hF000, 0,  80, 300);
        run_phase(16'd0,     16'd0,     16'hFFF8,  16'h03C3, 9,  9,  150);
        run_phase(16'hFFFF,  16'hFFFF,  16'd2,     16'h0FFF, 0,  0,  80);
        run_phase(16'd6,     16'd2,     16'd6,     16'h0555, 0,  80, 220);
        run_phase(16'd6,     16'd2,     16'd2,     16'h0AAA, 80, 0,  200);
        run_phase(16'd14,    16'd9,     16'd5,     16'h00C3, 9,  9,  180);
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial
    begin
        reset_servo_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_gap();
        test_pulse_widths();
        test_random_traffic();

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transfers (%0d ticks, %0d table writes) under %0d settings.",
                 n_items, n_ticks, n_writes, n_settings);
        $display("Checked %0d frame starts; %0d mismatches found.", n_frames, errors);
        if (errors == 0 && pending_reports.size() == 0)
        begin
            $display("PASS timeslot_servo_pwm_bank_core");
        end
        else
        begin
            $display("FAIL timeslot_servo_pwm_bank_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tspb_pkg.sv
rtl/tspb_chan_table.sv
rtl/tspb_sequencer.sv
rtl/timeslot_servo_pwm_bank_core.sv
test/tb_timeslot_servo_pwm_bank_core.sv
